FILE: rtl/core/pcsc_pkg.sv
package pcsc_pkg;

  // Conversion mode codes
  localparam logic [2:0] MODE_PASS = 3'd0;
  localparam logic [2:0] MODE_GRAY = 3'd1;
  localparam logic [2:0] MODE_CMY  = 3'd2;
  localparam logic [2:0] MODE_XYZ  = 3'd3;
  localparam logic [2:0] MODE_YUV  = 3'd4;

  // Register map
  localparam int unsigned APB_ADDR_W  = 3;
  localparam logic        REG_MODE_IX = 1'b0;

  // Fixed point: 12 fraction bits
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned ACC_W     = 24;

  // Gray: sum / 3 as sum * 683 >> 11, exact for sums up to 765
  localparam logic [9:0]  DIV3_MUL   = 10'd683;
  localparam int unsigned DIV3_SHIFT = 11;

  typedef logic signed [12:0] coef_t;

  // Matrix rows give output channels, columns give R, G, B
  localparam coef_t XYZ_COEF [3][3] = '{
    '{13'sd1688, 13'sd1462, 13'sd737 },
    '{13'sd868,  13'sd2929, 13'sd295 },
    '{13'sd78,   13'sd487,  13'sd3891}
  };

  localparam coef_t YUV_COEF [3][3] = '{
    '{13'sd1225,  13'sd2404,  13'sd467 },
    '{-13'sd692,  -13'sd1356, 13'sd2048},
    '{13'sd2048,  -13'sd1716, -13'sd332}
  };

  // Chroma offset of 128 in fixed point
  localparam logic signed [ACC_W-1:0] CHROMA_OFS = 24'sd524288;

  typedef struct packed {
    logic [2:0] mode;
  } cfg_t;

endpackage

FILE: rtl/core/pcsc_apb_regs.sv
module pcsc_apb_regs
  import pcsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [2:0] mode_q;
  logic [2:0] mode_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_MODE_IX);

  // Take the mode on a completed write to register zero
  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = pwdata[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PASS;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Read back; addresses past the map return zero
  assign prdata     = (paddr[2] == REG_MODE_IX) ? {29'd0, mode_q} : 32'd0;
  assign cfg_o.mode = mode_q;

endmodule

FILE: rtl/core/pcsc_convert.sv
module pcsc_convert
  import pcsc_pkg::*;
(
  input  cfg_t       cfg_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic [7:0] chan0_o,
  output logic [7:0] chan1_o,
  output logic [7:0] chan2_o
);

  logic signed [8:0]       px   [3];
  logic signed [21:0]      prod [3][3];
  logic signed [ACC_W-1:0] acc  [3];
  logic [7:0]              mat  [3];
  logic [9:0]              sum3;
  logic [19:0]             gray_prod;
  logic [7:0]              gray;
  logic                    yuv;

  assign px[0] = signed'({1'b0, red_i});
  assign px[1] = signed'({1'b0, green_i});
  assign px[2] = signed'({1'b0, blue_i});
  assign yuv   = (cfg_i.mode == MODE_YUV);

  // Matrix rows: three products, chroma offset in YUV mode, shift and clamp
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod[k][j] = (yuv ? YUV_COEF[k][j] : XYZ_COEF[k][j]) * px[j];
      end
      acc[k] = ACC_W'(prod[k][0]) + ACC_W'(prod[k][1]) + ACC_W'(prod[k][2]);
      if (yuv && (k != 0)) begin
        acc[k] = acc[k] + CHROMA_OFS;
      end
      if (acc[k][ACC_W-1]) begin
        mat[k] = 8'd0;
      end else if (|acc[k][ACC_W-2:FRAC_BITS+8]) begin
        mat[k] = 8'hFF;
      end else begin
        mat[k] = acc[k][FRAC_BITS+7:FRAC_BITS];
      end
    end
  end

  // Gray: channel sum divided by three via reciprocal multiply
  assign sum3      = 10'(red_i) + 10'(green_i) + 10'(blue_i);
  assign gray_prod = 20'(sum3) * 20'(DIV3_MUL);
  assign gray      = gray_prod[DIV3_SHIFT+7:DIV3_SHIFT];

  // Select the result for the active mode
  always_comb begin
    case (cfg_i.mode)
      MODE_GRAY: begin
        chan0_o = gray;
        chan1_o = 8'd0;
        chan2_o = 8'd0;
      end
      MODE_CMY: begin
        chan0_o = ~red_i;
        chan1_o = ~green_i;
        chan2_o = ~blue_i;
      end
      MODE_XYZ, MODE_YUV: begin
        chan0_o = mat[0];
        chan1_o = mat[1];
        chan2_o = mat[2];
      end
      default: begin
        chan0_o = red_i;
        chan1_o = green_i;
        chan2_o = blue_i;
      end
    endcase
  end

endmodule

FILE: rtl/core/pixel_color_space_converter_unit.sv
// Channel      Dir  Handshake                   Contents
// s_axis       in   tvalid/tready               source pixel: red, green, blue
// m_axis       out  tvalid/tready               converted pixel: chan0, chan1, chan2
// apb          in   psel/penable/pwrite/pready  conversion_mode at byte address 0
//
// One pixel per cycle unless m_axis stalls; stages: input register, result register.
// The conversion is combinational logic between the two registers.
// Reset (rst_ni low, asynchronous) empties both stages and sets mode to pass-through.
// Stalls on m_axis fill the input register and then drop s_axis_tready.
module pixel_color_space_converter_unit
  import pcsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // red_in, green_in, blue_in
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // chan0_out, chan1_out, chan2_out
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t        cfg;
  logic        in_vld_q, in_vld_d;
  logic [23:0] pix_q, pix_d;
  logic        res_vld_q, res_vld_d;
  logic [23:0] res_q, res_d;
  logic        res_adv;
  logic        in_adv;
  logic [7:0]  c0, c1, c2;

  pcsc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcsc_convert u_conv (
    .cfg_i   (cfg),
    .red_i   (pix_q[7:0]),
    .green_i (pix_q[15:8]),
    .blue_i  (pix_q[23:16]),
    .chan0_o (c0),
    .chan1_o (c1),
    .chan2_o (c2)
  );

  // Advance each stage when the one after it can take a word
  assign res_adv       = !res_vld_q || m_axis_tready;
  assign in_adv        = !in_vld_q || res_adv;
  assign s_axis_tready = in_adv;

  always_comb begin
    in_vld_d  = in_vld_q;
    pix_d     = pix_q;
    res_vld_d = res_vld_q;
    res_d     = res_q;
    if (res_adv) begin
      res_vld_d = in_vld_q;
      res_d     = {c2, c1, c0};
    end
    if (in_adv) begin
      in_vld_d = s_axis_tvalid;
      pix_d    = s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    res_q <= res_d;
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = res_q;

endmodule

FILE: rtl/core/pcsc_checker.sv
module pcsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic [1:0] cnt_q, cnt_d;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  // Count words held inside the block
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != 2'd0)
    else $error("result word without an accepted pixel");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("more words held than stages");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && cnt_q == 2'd2)
    else $error("input blocked without an output stall");

endmodule

bind pixel_color_space_converter_unit pcsc_checker u_pcsc_checker (.*);

FILE: verif/pcsc_stream_checker.sv
module pcsc_stream_checker
  import pcsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [23:0]           s_data_i,    // red_in, green_in, blue_in
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [23:0]           m_data_i,    // chan0_out, chan1_out, chan2_out
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [31:0]           pwdata_i,
  input  logic [31:0]           prdata_i,
  output int                    fail_count_o,
  output int                    pending_count_o,
  output int                    checked_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_W-1:0] MODE_ADDR = {REG_MODE_IX, 2'b00};
  localparam int FRAC_SHIFT  = 12;
  localparam int BYTE_MAX    = 255;
  localparam int CHROMA_BIAS = 128 << FRAC_SHIFT;

  // Channel 0 sits in the low byte, as on the bus
  typedef struct packed {
    logic [7:0] ch2;
    logic [7:0] ch1;
    logic [7:0] ch0;
  } pixel_t;

  pixel_t     expected_pixels[$];
  logic [2:0] conv_mode     = MODE_PASS;
  int         fail_total    = 0;
  int         checked_total = 0;

  // Drop the fraction bits and clamp to one byte
  function automatic logic [7:0] fixed_to_byte(input int acc);
    if (acc < 0) return 8'd0;
    if ((acc >>> FRAC_SHIFT) > BYTE_MAX) return 8'hFF;
    return 8'(acc >>> FRAC_SHIFT);
  endfunction

  function automatic pixel_t convert_pixel(input logic [2:0] mode,
                                           input logic [7:0] r, g, b);
    pixel_t px;
    int     ri, gi, bi;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    case (mode)
      MODE_GRAY: begin
        px.ch0 = 8'((ri + gi + bi) / 3);
        px.ch1 = 8'd0;
        px.ch2 = 8'd0;
      end
      // 255 minus an 8-bit value is its inverse
      MODE_CMY: px = {~b, ~g, ~r};
      MODE_XYZ: begin
        px.ch0 = fixed_to_byte(1688 * ri + 1462 * gi + 737 * bi);
        px.ch1 = fixed_to_byte(868 * ri + 2929 * gi + 295 * bi);
        px.ch2 = fixed_to_byte(78 * ri + 487 * gi + 3891 * bi);
      end
      MODE_YUV: begin
        px.ch0 = fixed_to_byte(1225 * ri + 2404 * gi + 467 * bi);
        px.ch1 = fixed_to_byte(-692 * ri - 1356 * gi + 2048 * bi + CHROMA_BIAS);
        px.ch2 = fixed_to_byte(2048 * ri - 1716 * gi - 332 * bi + CHROMA_BIAS);
      end
      default: px = {b, g, r};
    endcase
    return px;
  endfunction

  task automatic compare_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk_i) begin : track
    pixel_t want;
    pixel_t got;
    if (!rst_ni) begin
      conv_mode = MODE_PASS;
      expected_pixels.delete();
    end else begin
      // Compare each word leaving the converter with the oldest prediction
      if (m_valid_i && m_ready_i) begin
        got = m_data_i;
        if (expected_pixels.size() == 0) begin
          $error("output word %h with no pixel pending", got);
          fail_total++;
        end else begin
          want = expected_pixels.pop_front();
          compare_channel("chan0_out", want.ch0, got.ch0);
          compare_channel("chan1_out", want.ch1, got.ch1);
          compare_channel("chan2_out", want.ch2, got.ch2);
          checked_total++;
        end
      end
      // Predict each accepted source pixel under the current mode
      if (s_valid_i && s_ready_i)
        expected_pixels.push_back(convert_pixel(conv_mode, s_data_i[7:0],
                                                s_data_i[15:8], s_data_i[23:16]));
      // Follow mode writes; check read-back of the mode register
      if (psel_i && penable_i && pready_i && paddr_i == MODE_ADDR) begin
        if (pwrite_i) begin
          conv_mode = pwdata_i[2:0];
        end else if (prdata_i[2:0] !== conv_mode) begin
          $error("conversion_mode: expected %0d, got %0d", conv_mode, prdata_i[2:0]);
          fail_total++;
        end
      end
    end
    fail_count_o    <= fail_total;
    pending_count_o <= expected_pixels.size();
    checked_count_o <= checked_total;
  end

endmodule

FILE: verif/tb_pixel_color_space_converter_unit.sv
module tb_pixel_color_space_converter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pcsc_pkg::*;

  localparam int CLK_HALF           = 6;
  localparam int RESET_CYCLES       = 9;
  localparam int CYCLE_LIMIT        = 200000;
  localparam int DRAIN_CYCLES       = 8;
  localparam int IDLE_PROFILES      = 4;
  localparam int SEGMENTS_PER_PHASE = 4;
  localparam int WORDS_PER_SEGMENT  = 25;
  localparam int MODE_CODES         = 8;

  localparam logic [APB_ADDR_W-1:0] MODE_ADDR     = {REG_MODE_IX, 2'b00};
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = {1'b1, 2'b00};

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;   // red_in, green_in, blue_in
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [23:0]           m_axis_tdata;   // chan0_out, chan1_out, chan2_out
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  int cycle_cnt    = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  always #(CLK_HALF * 1ns) clk_i = ~clk_i;

  pixel_color_space_converter_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  pcsc_stream_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_valid_i       (s_axis_tvalid),
    .s_ready_i       (s_axis_tready),
    .s_data_i        (s_axis_tdata),
    .m_valid_i       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_data_i        (m_axis_tdata),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .fail_count_o    (fail_cnt),
    .pending_count_o (pending_cnt),
    .checked_count_o (checked_cnt)
  );

  // Stall the result side at the current rate
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycle_cnt, pending_cnt);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mostly uniform channel levels, with the rails mixed in
  function automatic logic [7:0] channel_level();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the source idle until every predicted pixel has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // Write the mode with junk in the unused upper bits, then read it back
  task automatic set_mode(input logic [2:0] mode);
    wait_drained();
    apb_access(1'b1, MODE_ADDR, (32'($urandom) & ~32'h7) | 32'(mode));
    apb_access(1'b0, MODE_ADDR, 32'd0);
  endtask

  initial begin
    int         k;
    int         seg_ix;
    logic [2:0] mode_sel;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pass-through straight out of reset
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h5A, 8'hA5, 8'hC3);

    // Gray: full scale, and truncation of the divide
    set_mode(MODE_GRAY);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h01, 8'h01, 8'h00);
    send_pixel(8'h02, 8'h02, 8'h01);

    set_mode(MODE_CMY);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h0F, 8'hF0);

    // XYZ: zero, and Z saturating at white and near-blue
    set_mode(MODE_XYZ);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h80, 8'hFF);

    // YUV: primaries stretch the chroma channels both ways
    set_mode(MODE_YUV);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF);

    // Undefined mode codes fall back to pass-through
    for (k = 1; k <= 3; k++) begin
      set_mode(MODE_YUV + 3'(k));
      send_pixel(channel_level(), channel_level(), channel_level());
    end

    // A write off the register map must leave the mode alone
    wait_drained();
    apb_access(1'b1, UNMAPPED_ADDR, $urandom);
    apb_access(1'b0, MODE_ADDR, 32'd0);
    send_pixel(channel_level(), channel_level(), channel_level());

    // Random pixels; idle profiles 0-1 sweep all mode codes, 2-3 random modes
    for (k = 0; k < IDLE_PROFILES; k++) begin
      wait_drained();
      case (k)
        0:       begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
        1:       begin tx_idle_pct <= 52; rx_stall_pct <= 0;  end
        2:       begin tx_idle_pct <= 0;  rx_stall_pct <= 52; end
        default: begin tx_idle_pct <= 36; rx_stall_pct <= 36; end
      endcase
      for (seg_ix = 0; seg_ix < SEGMENTS_PER_PHASE; seg_ix++) begin
        if (k * SEGMENTS_PER_PHASE + seg_ix < MODE_CODES)
          mode_sel = 3'(k * SEGMENTS_PER_PHASE + seg_ix);
        else
          mode_sel = 3'($urandom_range(MODE_CODES - 1));
        set_mode(mode_sel);
        repeat (WORDS_PER_SEGMENT)
          send_pixel(channel_level(), channel_level(), channel_level());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Converted and compared %0d pixels over all eight mode codes,", checked_cnt);
    $display("with rail values, saturation and idle/stall mixes on both stream ports.");
    if (fail_cnt == 0 && pending_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pcsc_pkg.sv
rtl/core/pcsc_apb_regs.sv
rtl/core/pcsc_convert.sv
rtl/core/pixel_color_space_converter_unit.sv
rtl/core/pcsc_checker.sv
verif/pcsc_stream_checker.sv
verif/tb_pixel_color_space_converter_unit.sv
